FILE: rtl/core/dhc_pkg.sv
// Package with the shared types and constants of the diagonal hit chainer.
`default_nettype none
package dhc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_HIT   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_MER   = 2'd0,
    CFG_QLEN  = 2'd1,
    CFG_REV   = 2'd2,
    CFG_NSEQ  = 2'd3
  } cfg_e;

  localparam int unsigned CfgIdxW = 2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  entry_index;
    logic [31:0] seq_start;
    logic [31:0] seq_id;
    logic [31:0] query_pos;
    logic [31:0] target_pos;
    logic [31:0] diagonal_id;
  } req_t;

  typedef struct packed {
    logic [31:0] query_start;
    logic [31:0] query_span;
    logic [31:0] sequence_ident;
    logic [31:0] target_start;
    logic [31:0] target_span;
    logic        hits_dropped;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/dhc_if.sv
// Valid/ready channel interface that carries one payload type.
`default_nettype none
interface dhc_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dhc_front.sv
// Front part: passes requests through a short queue, NOPs dropped.
`default_nettype none
module dhc_front
  import dhc_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output       logic in_ready_o,
  input  wire  req_t in_data_i,
  output       logic q_valid_o,
  input  wire  logic q_ready_i,
  output       req_t q_data_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  req_t              mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              push, pop;

  assign in_ready_o = (cnt_q != (PtrW+1)'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = mem_q[rd_q];
  assign push       = in_valid_i && in_ready_o && (in_data_i.opcode != OP_NOP);
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/dhc_back.sv
// Back part: table lookup, hit store, flush sort and chain emission.
`default_nettype none
module dhc_back
  import dhc_pkg::*;
#(
  parameter int unsigned MaxHits    = 64,
  parameter int unsigned SeqEntries = 16
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        q_valid_i,
  output       logic        q_ready_o,
  input  wire  req_t        q_data_i,
  input  wire  logic [5:0]  mer_size_i,
  input  wire  logic [31:0] query_length_i,
  input  wire  logic        reverse_i,
  input  wire  logic [4:0]  seq_in_use_i,
  output       logic        out_valid_o,
  input  wire  logic        out_ready_i,
  output       res_t        out_data_o,
  output       logic        busy_o
);
  localparam int unsigned HW = $clog2(MaxHits);
  localparam int unsigned CW = HW + 1;
  localparam int unsigned SW = (SeqEntries > 1) ? $clog2(SeqEntries) : 1;
  localparam int unsigned KW = 4 + 64;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_SRD   = 7'b0000100,
    ST_SCMP  = 7'b0001000,
    ST_CRD   = 7'b0010000,
    ST_CSTEP = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] start_q [SeqEntries];
  logic [31:0] ident_q [SeqEntries];

  // Hit memories: key = {slot, diagonal, query}, plus relative target.
  logic [KW-1:0] key_mem [MaxHits];
  logic [31:0]   tgt_mem [MaxHits];
  logic [KW-1:0] ka_q, kb_q;
  logic [31:0]   ta_q, tb_q;

  logic [CW-1:0] cnt_q;
  logic          drop_q;
  logic [SW:0]   scan_q;
  logic [4:0]    nseq;
  req_t          cur_q;
  logic [HW-1:0] i_q, j_q;
  logic          swapped_q;
  logic          wr_phase_q;

  // Chain registers.
  logic [3:0]    slot_q;
  logic [31:0]   diag_q, qlo_q, qhi_q, dlo_q, dhi_q;
  logic          chain_first_q;
  logic          fin_q;
  res_t          res_q;
  logic          res_v_q;

  assign nseq = (seq_in_use_i == '0) ? 5'd1 :
                (seq_in_use_i > 5'(SeqEntries)) ? 5'(SeqEntries) : seq_in_use_i;
  assign q_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o = res_v_q;
  assign out_data_o  = res_q;
  assign busy_o      = (state_q != ST_IDLE) || res_v_q;

  logic [31:0] mer32;
  assign mer32 = {26'd0, mer_size_i};

  logic scan_hit;
  assign scan_hit = (scan_q < (SW+1)'(nseq)) &&
                    (start_q[scan_q[SW-1:0]] <= cur_q.target_pos);

  logic        join_ok;
  logic [31:0] qn, tn;
  assign qn = kb_q[31:0];
  assign tn = tb_q;
  assign join_ok = (kb_q[KW-1:64] == slot_q) && (kb_q[63:32] == diag_q) &&
                   (qlo_q <= qn) && (qn <= qhi_q + mer32);

  function automatic res_t make_res(input logic [3:0] s, input logic [31:0] ql,
                                    input logic [31:0] qh, input logic [31:0] dl,
                                    input logic [31:0] dh, input logic lst);
    res_t r;
    r.query_start    = reverse_i ? (query_length_i - qh - mer32) : ql;
    r.query_span     = qh - ql + mer32;
    r.sequence_ident = ident_q[s[SW-1:0]];
    r.target_start   = dl;
    r.target_span    = dh - dl + mer32;
    r.hits_dropped   = drop_q;
    r.last           = lst;
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_data_i.opcode == OP_HIT) begin
            state_d = ST_SCAN;
          end else if (q_data_i.opcode == OP_FLUSH && cnt_q != '0) begin
            state_d = (cnt_q > CW'(1)) ? ST_SRD : ST_CRD;
          end
        end
      end
      ST_SCAN:  if (!scan_hit) state_d = ST_IDLE;
      ST_SRD:   state_d = ST_SCMP;
      ST_SCMP:  begin
        if (wr_phase_q || kb_q >= ka_q) begin
          if (32'(j_q) + 32'd2 >= 32'(cnt_q)) begin
            state_d = (swapped_q || (wr_phase_q == 1'b0 && kb_q < ka_q)) ? ST_SRD : ST_CRD;
          end else begin
            state_d = ST_SRD;
          end
        end
      end
      ST_CRD:   state_d = ST_CSTEP;
      ST_CSTEP: state_d = ST_EMIT;
      ST_EMIT:  begin
        if (!res_v_q || out_ready_i) begin
          state_d = fin_q ? ST_IDLE : ST_CRD;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < SeqEntries; k++) begin
        start_q[k] <= '0;
        ident_q[k] <= '0;
      end
    end else if (state_q == ST_IDLE && q_valid_i && q_data_i.opcode == OP_LOAD &&
                 32'(q_data_i.entry_index) < SeqEntries) begin
      start_q[q_data_i.entry_index[SW-1:0]] <= q_data_i.seq_start;
      ident_q[q_data_i.entry_index[SW-1:0]] <= q_data_i.seq_id;
    end
  end

  // Memory writes: append on a hit, swap writes during the sort.
  logic          mw_en;
  logic [HW-1:0] mw_a;
  logic [KW-1:0] mw_k;
  logic [31:0]   mw_t;
  always_comb begin
    mw_en = 1'b0;
    mw_a  = cnt_q[HW-1:0];
    mw_k  = {4'(scan_q - 1'b1), cur_q.diagonal_id, cur_q.query_pos};
    mw_t  = cur_q.target_pos - start_q[SW'(scan_q - 1'b1)];
    if (state_q == ST_SCAN && !scan_hit && scan_q != '0 && cnt_q < CW'(MaxHits)) begin
      mw_en = 1'b1;
    end else if (state_q == ST_SCMP && !wr_phase_q && kb_q < ka_q) begin
      mw_en = 1'b1;
      mw_a  = j_q;
      mw_k  = kb_q;
      mw_t  = tb_q;
    end else if (state_q == ST_SCMP && wr_phase_q) begin
      mw_en = 1'b1;
      mw_a  = HW'(j_q + 1'b1);
      mw_k  = ka_q;
      mw_t  = ta_q;
    end
  end

  logic [HW-1:0] ra_a, ra_b;
  assign ra_a = (state_q == ST_CRD || state_q == ST_CSTEP || state_q == ST_EMIT)
                ? i_q : j_q;
  assign ra_b = HW'(j_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (mw_en) begin
      key_mem[mw_a] <= mw_k;
      tgt_mem[mw_a] <= mw_t;
    end
    if (state_q == ST_SRD) begin
      ka_q <= key_mem[j_q];
      ta_q <= tgt_mem[j_q];
      kb_q <= key_mem[ra_b];
      tb_q <= tgt_mem[ra_b];
    end else if (state_q == ST_CRD) begin
      kb_q <= key_mem[ra_a];
      tb_q <= tgt_mem[ra_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      drop_q        <= 1'b0;
      scan_q        <= '0;
      i_q           <= '0;
      j_q           <= '0;
      swapped_q     <= 1'b0;
      wr_phase_q    <= 1'b0;
      res_v_q       <= 1'b0;
      chain_first_q <= 1'b0;
      fin_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_v_q && out_ready_i && !(state_q == ST_EMIT && fin_q)) begin
        res_v_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            cur_q     <= q_data_i;
            scan_q    <= '0;
            j_q       <= '0;
            i_q       <= '0;
            swapped_q <= 1'b0;
            wr_phase_q    <= 1'b0;
            chain_first_q <= 1'b1;
            if (q_data_i.opcode == OP_FLUSH && cnt_q == '0) begin
              drop_q <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            scan_q <= scan_q + 1'b1;
          end else if (scan_q == '0 || cnt_q >= CW'(MaxHits)) begin
            drop_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SCMP: begin
          if (!wr_phase_q && kb_q < ka_q) begin
            wr_phase_q <= 1'b1;
            swapped_q  <= 1'b1;
          end else begin
            wr_phase_q <= 1'b0;
            if (32'(j_q) + 32'd2 >= 32'(cnt_q)) begin
              j_q       <= '0;
              swapped_q <= 1'b0;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        ST_CSTEP: begin
          fin_q <= (32'(i_q) + 32'd1 >= 32'(cnt_q));
          if (chain_first_q) begin
            chain_first_q <= 1'b0;
            slot_q <= kb_q[KW-1:64];
            diag_q <= kb_q[63:32];
            qlo_q  <= qn;
            qhi_q  <= qn;
            dlo_q  <= tn;
            dhi_q  <= tn;
          end else if (join_ok) begin
            if (qn > qhi_q) qhi_q <= qn;
            if (tn < dlo_q) dlo_q <= tn;
            if (tn > dhi_q) dhi_q <= tn;
          end
        end
        ST_EMIT: begin
          if (!res_v_q || out_ready_i) begin
            i_q <= i_q + 1'b1;
            if (fin_q) begin
              res_v_q <= 1'b1;
              res_q   <= make_res(slot_q, qlo_q, qhi_q, dlo_q, dhi_q, 1'b1);
              cnt_q   <= '0;
              drop_q  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
      // A breaking hit closes the running chain and opens a new one.
      if (state_q == ST_CSTEP && !chain_first_q && !join_ok) begin
        res_v_q <= 1'b1;
        res_q   <= make_res(slot_q, qlo_q, qhi_q, dlo_q, dhi_q, 1'b0);
        slot_q  <= kb_q[KW-1:64];
        diag_q  <= kb_q[63:32];
        qlo_q   <= qn;
        qhi_q   <= qn;
        dlo_q   <= tn;
        dhi_q   <= tn;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/diagonal_hit_chainer.sv
// Top level of the diagonal hit chainer: channels, configuration and checks.
// Requests enter on req (load table entry, add hit, flush); chains leave on res.
// Configuration is written on cfg while the block is idle: a rule for the
// user, which the block leaves unchecked. Index 0 mer size, 1 query length,
// 2 reverse flag, 3 sequences in use. A request passes a two-entry queue
// into the back part, which takes one request at a time. A hit runs a
// serial scan of the sequence start table. A flush of n hits runs a bubble
// sort over the hit memory, whose single write port writes a swap's two
// entries in turn, then a chaining pass that reads and steps through each
// hit; each chain is one result, the final one flagged with last. An empty
// flush emits nothing. Reset empties the queue and the hit store and
// restores the register defaults; the sequence table reads zero after
// reset. When the receiver stalls the result register holds and the
// chaining pass waits; requests fill the queue and then see ready low.
`default_nettype none
module diagonal_hit_chainer
  import dhc_pkg::*;
#(
  parameter int unsigned MAX_HITS    = 64,
  parameter int unsigned SEQ_ENTRIES = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  dhc_if.sink      req,
  dhc_if.source    res,
  dhc_if.sink      cfg
);
  logic [5:0]  mer_q;
  logic [31:0] qlen_q;
  logic        rev_q;
  logic [4:0]  nseq_q;
  logic        qv, qr, busy;
  req_t        qd;
  logic [31:0] sreset_unused;

  assign cfg.ready = 1'b1;
  assign sreset_unused = '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mer_q  <= 6'd20;
      qlen_q <= '0;
      rev_q  <= 1'b0;
      nseq_q <= 5'd1;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_MER:  mer_q  <= cfg.data.data[5:0];
        CFG_QLEN: qlen_q <= cfg.data.data;
        CFG_REV:  rev_q  <= cfg.data.data[0];
        CFG_NSEQ: nseq_q <= cfg.data.data[4:0];
        default:  ;
      endcase
    end
  end

  dhc_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .in_data_i  (req.data),
    .q_valid_o  (qv),
    .q_ready_i  (qr),
    .q_data_o   (qd)
  );

  dhc_back #(.MaxHits(MAX_HITS), .SeqEntries(SEQ_ENTRIES)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i      (qv),
    .q_ready_o      (qr),
    .q_data_i       (qd),
    .mer_size_i     (mer_q),
    .query_length_i (qlen_q | sreset_unused),
    .reverse_i      (rev_q),
    .seq_in_use_i   (nseq_q),
    .out_valid_o    (res.valid),
    .out_ready_i    (res.ready),
    .out_data_o     (res.data),
    .busy_o         (busy)
  );

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res.ready |=> res.valid && $stable(res.data))
    else $error("result changed under stall");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> busy)
    else $error("result valid while back part idle");
  a_queue_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qv && qr |-> !res.valid || busy)
    else $error("queue pop inconsistent with back state");
endmodule
`default_nettype wire
